[design/fbma_pkg.sv]
// Shared types, codes and the saturating add for the band matrix assembler.
// No dependencies; the cell map, the core and the bench refer to it by scoped names.
package fbma_pkg;

   // Field widths fixed by the beat formats
   localparam int KIND_W     = 2;
   localparam int LIDX_W     = 5;
   localparam int GIDX_W     = 6;
   localparam int BW_W       = 6;
   localparam int VALUE_W    = 64;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;

   // Signed width for cell arithmetic, wide enough for any supported store size
   localparam int CALC_W = 12;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ADD  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_SKIPPED = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_DROPPED = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_SAT     = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SYMMETRIC = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BANDED    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_BW  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_BW  = 2'd3;

   // Storage layout settings
   typedef struct packed {
      logic            symmetric;
      logic            banded;
      logic [BW_W-1:0] lower_bw;
      logic [BW_W-1:0] upper_bw;
   } cfg_type;

   typedef struct packed {
      logic               ovf;
      logic [VALUE_W-1:0] sum;
   } sat_type;

   // Two's complement add that clamps to the most positive or negative word
   function automatic sat_type sat_add(input logic [VALUE_W-1:0] a,
                                       input logic [VALUE_W-1:0] b);
      sat_type            res;
      logic [VALUE_W-1:0] s;
      s       = a + b;
      res.ovf = (a[VALUE_W-1] == b[VALUE_W-1]) && (s[VALUE_W-1] != a[VALUE_W-1]);
      if (res.ovf) begin
         res.sum = a[VALUE_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                : {1'b0, {(VALUE_W-1){1'b1}}};
      end else begin
         res.sum = s;
      end
      return res;
   endfunction

endpackage

[design/fbma_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fbma_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write on enable, read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/fbma_cell_map.sv]
// Maps a global (row, column) pair to a storage cell for the selected layout.
// Depends on fbma_pkg for the layout settings type and widths.
module fbma_cell_map #(
   parameter int MAX_DOF = 64
) (
   input  fbma_pkg::cfg_type                cfg,
   input  logic [fbma_pkg::GIDX_W-1:0]      glob_row,
   input  logic [fbma_pkg::GIDX_W-1:0]      glob_col,
   output logic [2*$clog2(MAX_DOF)-1:0]     cell_addr,
   output logic                             keep
);

   localparam int DOF_W = $clog2(MAX_DOF);
   localparam int CW    = fbma_pkg::CALC_W;
   localparam int GW    = fbma_pkg::GIDX_W;
   localparam int BW    = fbma_pkg::BW_W;
   localparam logic signed [CW-1:0] DOF_LIMIT = CW'(MAX_DOF);

   logic signed [CW-1:0] rs, cs, ls, us;
   logic signed [CW-1:0] lo, hi, diff;
   logic signed [CW-1:0] srow, scol;
   logic                 band_ok;

   // Widen every index to signed arithmetic
   always_comb begin
      rs   = $signed({{(CW-GW){1'b0}}, glob_row});
      cs   = $signed({{(CW-GW){1'b0}}, glob_col});
      ls   = $signed({{(CW-BW){1'b0}}, cfg.lower_bw});
      us   = $signed({{(CW-BW){1'b0}}, cfg.upper_bw});
      lo   = (rs < cs) ? rs : cs;
      hi   = (rs < cs) ? cs : rs;
      diff = rs - cs;
   end

   // Pick the layout
   always_comb begin
      unique case ({cfg.symmetric, cfg.banded})
         2'b11: begin
            srow    = hi - lo;
            scol    = lo;
            band_ok = (hi - lo) <= ls;
         end
         2'b10: begin
            srow    = hi;
            scol    = lo;
            band_ok = 1'b1;
         end
         2'b01: begin
            srow    = diff + ls + us;
            scol    = cs;
            band_ok = (diff <= ls) && ((cs - rs) <= us);
         end
         default: begin
            srow    = rs;
            scol    = cs;
            band_ok = 1'b1;
         end
      endcase
   end

   // Drop cells outside the band or outside the store
   assign keep = band_ok && (rs < DOF_LIMIT) && (cs < DOF_LIMIT) &&
                 (srow >= 0) && (srow < DOF_LIMIT) && (scol < DOF_LIMIT);

   assign cell_addr = {srow[DOF_W-1:0], scol[DOF_W-1:0]};

endmodule

[design/fem_band_matrix_assembler_core.sv]
// Top level of the band matrix assembler: control sequencer, registers, memories.
// Depends on fbma_pkg, fbma_ram and fbma_cell_map.
//
//  channel | ports                        | direction | beat
//  req     | req_valid / req_stall        | in        | load, add or read request
//  rsp     | rsp_valid / rsp_stall        | out       | status and read word
//  csr     | csr_write, csr_index/wdata   | in        | one register write
//
// A load or unknown request goes from idle straight to the reply step, a read
// runs fetch and accumulate, and an add runs map, fetch and accumulate in turn:
// DOF map read and cell mapping, matrix read, write back. After reset the store
// is swept to zero, one word a cycle, over all 2**(2*clog2(MAX_DOF)) words (4096
// by default) while req_stall is high. A stalled response waits in its register;
// the next request is accepted meanwhile, and only its reply waits for the register.
module fem_band_matrix_assembler_core #(
   parameter int MAX_DOF      = 64,
   parameter int MAX_ELEM_DOF = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [fbma_pkg::KIND_W-1:0]              req_type,
   input  logic [fbma_pkg::LIDX_W-1:0]              req_local_row,
   input  logic [fbma_pkg::LIDX_W-1:0]              req_local_col,
   input  logic [fbma_pkg::GIDX_W-1:0]              req_global_index,
   input  logic [fbma_pkg::GIDX_W-1:0]              req_store_row,
   input  logic [fbma_pkg::GIDX_W-1:0]              req_store_col,
   input  logic signed [fbma_pkg::VALUE_W-1:0]      req_entry_value,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [fbma_pkg::STATUS_W-1:0]            rsp_status,
   output logic signed [fbma_pkg::VALUE_W-1:0]      rsp_read_value,
   input  logic                                     csr_write,
   input  logic [fbma_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [fbma_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   localparam int DOF_W      = $clog2(MAX_DOF);
   localparam int CELL_W     = 2 * DOF_W;
   localparam int CELL_DEPTH = 1 << CELL_W;
   localparam int EDOF_W     = $clog2(MAX_ELEM_DOF);
   localparam int CW         = fbma_pkg::CALC_W;
   localparam int VW         = fbma_pkg::VALUE_W;
   localparam int GW         = fbma_pkg::GIDX_W;
   localparam int SW         = fbma_pkg::STATUS_W;
   localparam int KW         = fbma_pkg::KIND_W;
   localparam int BW         = fbma_pkg::BW_W;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_MAP   = 6'b000100,
      ST_FETCH = 6'b001000,
      ST_ACC   = 6'b010000,
      ST_REPLY = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [CELL_W-1:0] clr_ff, clr_in;
   fbma_pkg::cfg_type cfg_ff, cfg_in;
   logic [KW-1:0]     kind_ff, kind_in;
   logic              pre_ok_ff, pre_ok_in;
   logic              hit_ff, hit_in;
   logic [CELL_W-1:0] addr_ff, addr_in;
   logic [SW-1:0]     status_ff, status_in;
   logic [VW-1:0]     value_ff, value_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]     rsp_status_ff, rsp_status_in;
   logic [VW-1:0]     rsp_value_ff, rsp_value_in;

   logic              req_accept;
   logic              rsp_free;
   logic              row_lidx_ok, col_lidx_ok;
   logic              store_ok;
   logic              dof_wr_en;
   logic [GW-1:0]     dof_row, dof_col;
   logic [CELL_W-1:0] map_addr;
   logic              map_keep;
   logic              mat_wr_en;
   logic [CELL_W-1:0] mat_wr_addr;
   logic [VW-1:0]     mat_wr_data;
   logic [VW-1:0]     mat_rdata;
   fbma_pkg::sat_type acc;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Range checks on the incoming beat
   assign row_lidx_ok = CW'(req_local_row) < CW'(MAX_ELEM_DOF);
   assign col_lidx_ok = CW'(req_local_col) < CW'(MAX_ELEM_DOF);
   assign store_ok    = (CW'(req_store_row) < CW'(MAX_DOF)) &&
                        (CW'(req_store_col) < CW'(MAX_DOF));

   // DOF map, one copy per lookup port, both written by loads
   assign dof_wr_en = req_accept && (req_type == fbma_pkg::KIND_LOAD) && row_lidx_ok;

   fbma_ram #(.WIDTH(GW), .DEPTH(MAX_ELEM_DOF)) u_dof_row (
      .clock   (clock),
      .wr_en   (dof_wr_en),
      .wr_addr (EDOF_W'(req_local_row)),
      .wr_data (req_global_index),
      .rd_addr (EDOF_W'(req_local_row)),
      .rd_data (dof_row)
   );

   fbma_ram #(.WIDTH(GW), .DEPTH(MAX_ELEM_DOF)) u_dof_col (
      .clock   (clock),
      .wr_en   (dof_wr_en),
      .wr_addr (EDOF_W'(req_local_row)),
      .wr_data (req_global_index),
      .rd_addr (EDOF_W'(req_local_col)),
      .rd_data (dof_col)
   );

   // Global pair to storage cell
   fbma_cell_map #(.MAX_DOF(MAX_DOF)) u_cell_map (
      .cfg       (cfg_ff),
      .glob_row  (dof_row),
      .glob_col  (dof_col),
      .cell_addr (map_addr),
      .keep      (map_keep)
   );

   // Matrix store
   fbma_ram #(.WIDTH(VW), .DEPTH(CELL_DEPTH)) u_matrix (
      .clock   (clock),
      .wr_en   (mat_wr_en),
      .wr_addr (mat_wr_addr),
      .wr_data (mat_wr_data),
      .rd_addr (addr_ff),
      .rd_data (mat_rdata)
   );

   assign acc = fbma_pkg::sat_add(mat_rdata, value_ff);

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            fbma_pkg::CSR_SYMMETRIC: cfg_in.symmetric = csr_wdata[0];
            fbma_pkg::CSR_BANDED:    cfg_in.banded    = csr_wdata[0];
            fbma_pkg::CSR_LOWER_BW:  cfg_in.lower_bw  = csr_wdata[BW-1:0];
            fbma_pkg::CSR_UPPER_BW:  cfg_in.upper_bw  = csr_wdata[BW-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      kind_in       = kind_ff;
      pre_ok_in     = pre_ok_ff;
      hit_in        = hit_ff;
      addr_in       = addr_ff;
      status_in     = status_ff;
      value_in      = value_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      mat_wr_en     = 1'b0;
      mat_wr_addr   = addr_ff;
      mat_wr_data   = acc.sum;

      unique case (state_ff)
         ST_CLEAR: begin
            // Sweep the store to zero
            mat_wr_en   = 1'b1;
            mat_wr_addr = clr_ff;
            mat_wr_data = '0;
            clr_in      = clr_ff + CELL_W'(1);
            if (clr_ff == {CELL_W{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               kind_in   = req_type;
               value_in  = req_entry_value;
               status_in = fbma_pkg::STAT_DONE;
               pre_ok_in = 1'b0;
               hit_in    = 1'b0;
               addr_in   = {DOF_W'(req_store_row), DOF_W'(req_store_col)};
               unique case (req_type)
                  fbma_pkg::KIND_LOAD: begin
                     value_in = '0;
                     state_in = ST_REPLY;
                  end
                  fbma_pkg::KIND_ADD: begin
                     if (!(row_lidx_ok && col_lidx_ok)) begin
                        status_in = fbma_pkg::STAT_DROPPED;
                     end else if (cfg_ff.symmetric && (req_local_row < req_local_col)) begin
                        status_in = fbma_pkg::STAT_SKIPPED;
                     end else begin
                        pre_ok_in = 1'b1;
                     end
                     state_in = ST_MAP;
                  end
                  fbma_pkg::KIND_READ: begin
                     hit_in   = store_ok;
                     state_in = ST_FETCH;
                  end
                  default: begin
                     value_in = '0;
                     state_in = ST_REPLY;
                  end
               endcase
            end
         end
         ST_MAP: begin
            // DOF map data is in; resolve the cell
            hit_in  = pre_ok_ff && map_keep;
            addr_in = map_addr;
            if (pre_ok_ff && !map_keep) begin
               status_in = fbma_pkg::STAT_DROPPED;
            end
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            // Accumulate and write back, or take the read word
            if (kind_ff == fbma_pkg::KIND_ADD) begin
               mat_wr_en = hit_ff;
               if (hit_ff) begin
                  status_in = acc.ovf ? fbma_pkg::STAT_SAT : fbma_pkg::STAT_DONE;
               end
               value_in = '0;
            end else begin
               value_in = hit_ff ? mat_rdata : '0;
            end
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            // Hand over once the response register is free
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_value_in  = value_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cfg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      pre_ok_ff     <= pre_ok_in;
      hit_ff        <= hit_in;
      addr_ff       <= addr_in;
      status_ff     <= status_in;
      value_ff      <= value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = $signed(rsp_value_ff);

   // A new response only comes out of the reply step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_REPLY))
      else $error("response raised outside the reply step");

   // Reads never modify the store
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC && kind_ff != fbma_pkg::KIND_ADD) |-> !mat_wr_en)
      else $error("store written by a non-add request");

   // Adds always report a zero read word
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC && kind_ff == fbma_pkg::KIND_ADD) |=> (value_ff == '0))
      else $error("add reply carries a read word");

   // No request is taken while the store is being cleared
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |=> ($past(clr_ff) == {CELL_W{1'b1}}) || req_stall)
      else $error("request window opened during clearing");

endmodule

[tb/tb_fem_band_matrix_assembler_core.sv]
// Self-checking bench for fem_band_matrix_assembler_core: map loads, entry adds and reads
// in all four storage layouts, checked against a mirror of the global matrix store.
// Depends on fbma_pkg and the core RTL; needs nothing else.
module tb_fem_band_matrix_assembler_core;

   localparam int GRID          = 64;
   localparam int ELEM_SLOTS    = 32;
   localparam int PHASE_ITEMS   = 192;
   localparam int SETTLE_CYCLES = 10;
   localparam int LONG_HOLD     = 300;
   localparam int RUN_LIMIT     = 1000000;

   // Request kind with no meaning to the block
   localparam logic [fbma_pkg::KIND_W-1:0] KIND_NONE = 2'd3;

   typedef struct {
      logic [fbma_pkg::KIND_W-1:0]  kind;
      logic [fbma_pkg::LIDX_W-1:0]  row;
      logic [fbma_pkg::LIDX_W-1:0]  col;
      logic [fbma_pkg::GIDX_W-1:0]  gidx;
      logic [fbma_pkg::GIDX_W-1:0]  srow;
      logic [fbma_pkg::GIDX_W-1:0]  scol;
      logic [fbma_pkg::VALUE_W-1:0] value;
   } assembly_request_type;

   typedef struct {
      logic [fbma_pkg::STATUS_W-1:0] status;
      logic [fbma_pkg::VALUE_W-1:0]  value;
   } assembly_reply_type;

   // Mirror of the DOF map, the matrix store and the layout registers, plus the
   // replies still owed by the block
   class global_matrix_mirror;
      logic [fbma_pkg::GIDX_W-1:0]  dof_slot [ELEM_SLOTS];
      logic [fbma_pkg::VALUE_W-1:0] cells [GRID*GRID];
      fbma_pkg::cfg_type            layout;
      assembly_reply_type           pending_replies [$];
      int                           mismatches;
      int                           hit_row;
      int                           hit_col;

      function new();
         foreach (cells[k]) cells[k] = '0;
         foreach (dof_slot[k]) dof_slot[k] = '0;
         layout     = '0;
         mismatches = 0;
         hit_row    = 0;
         hit_col    = 0;
      endfunction

      function void note_register(logic [fbma_pkg::CSR_IDX_W-1:0] index,
                                  logic [fbma_pkg::CSR_DATA_W-1:0] data);
         case (index)
            fbma_pkg::CSR_SYMMETRIC: layout.symmetric = data[0];
            fbma_pkg::CSR_BANDED:    layout.banded    = data[0];
            fbma_pkg::CSR_LOWER_BW:  layout.lower_bw  = data[fbma_pkg::BW_W-1:0];
            fbma_pkg::CSR_UPPER_BW:  layout.upper_bw  = data[fbma_pkg::BW_W-1:0];
            default: ;
         endcase
      endfunction

      // Work out the reply to one accepted request and update the mirror
      function void apply_request(assembly_request_type rq);
         assembly_reply_type           owed;
         int                           r, c, lo, hi, srow, scol, lbw, ubw, diff;
         bit                           keep;
         logic [fbma_pkg::VALUE_W-1:0] old, sum;
         owed.status = fbma_pkg::STAT_DONE;
         owed.value  = '0;
         case (rq.kind)
            fbma_pkg::KIND_LOAD: dof_slot[rq.row] = rq.gidx;
            fbma_pkg::KIND_READ: owed.value = cells[int'(rq.srow) * GRID + int'(rq.scol)];
            fbma_pkg::KIND_ADD: begin
               if (layout.symmetric && rq.row < rq.col) begin
                  owed.status = fbma_pkg::STAT_SKIPPED;
               end else begin
                  r    = int'(dof_slot[rq.row]);
                  c    = int'(dof_slot[rq.col]);
                  lbw  = int'(layout.lower_bw);
                  ubw  = int'(layout.upper_bw);
                  lo   = (r < c) ? r : c;
                  hi   = (r < c) ? c : r;
                  keep = 1'b1;
                  if (layout.symmetric && layout.banded) begin
                     srow = hi - lo;
                     scol = lo;
                     keep = (srow <= lbw);
                  end else if (layout.symmetric) begin
                     srow = hi;
                     scol = lo;
                  end else if (layout.banded) begin
                     diff = r - c;
                     srow = diff + lbw + ubw;
                     scol = c;
                     keep = (diff <= lbw) && (-diff <= ubw);
                  end else begin
                     srow = r;
                     scol = c;
                  end
                  if (!keep || srow < 0 || srow >= GRID || scol < 0 || scol >= GRID) begin
                     owed.status = fbma_pkg::STAT_DROPPED;
                  end else begin
                     // Accumulate, clamping on signed overflow
                     old = cells[srow * GRID + scol];
                     sum = old + rq.value;
                     if (old[fbma_pkg::VALUE_W-1] == rq.value[fbma_pkg::VALUE_W-1] &&
                         sum[fbma_pkg::VALUE_W-1] != old[fbma_pkg::VALUE_W-1]) begin
                        sum = old[fbma_pkg::VALUE_W-1] ?
                              {1'b1, {(fbma_pkg::VALUE_W-1){1'b0}}} :
                              {1'b0, {(fbma_pkg::VALUE_W-1){1'b1}}};
                        owed.status = fbma_pkg::STAT_SAT;
                     end
                     cells[srow * GRID + scol] = sum;
                     hit_row = srow;
                     hit_col = scol;
                  end
               end
            end
            default: ;
         endcase
         pending_replies.push_back(owed);
      endfunction

      // Compare one accepted reply with the oldest one owed
      function void compare_reply(logic [fbma_pkg::STATUS_W-1:0] status,
                                  logic [fbma_pkg::VALUE_W-1:0] value);
         assembly_reply_type owed;
         if (pending_replies.size() == 0) begin
            $error("reply with nothing outstanding: status %0d, read_value %h", status, value);
            mismatches++;
            return;
         end
         owed = pending_replies.pop_front();
         if (status !== owed.status) begin
            $error("status: expected %0d, actual %0d", owed.status, status);
            mismatches++;
         end
         if (value !== owed.value) begin
            $error("read_value: expected %h, actual %h", owed.value, value);
            mismatches++;
         end
      endfunction
   endclass

   logic                                 clock            = 1'b0;
   logic                                 reset            = 1'b1;
   logic                                 req_valid        = 1'b0;
   logic                                 req_stall;
   logic [fbma_pkg::KIND_W-1:0]          req_type         = '0;
   logic [fbma_pkg::LIDX_W-1:0]          req_local_row    = '0;
   logic [fbma_pkg::LIDX_W-1:0]          req_local_col    = '0;
   logic [fbma_pkg::GIDX_W-1:0]          req_global_index = '0;
   logic [fbma_pkg::GIDX_W-1:0]          req_store_row    = '0;
   logic [fbma_pkg::GIDX_W-1:0]          req_store_col    = '0;
   logic signed [fbma_pkg::VALUE_W-1:0]  req_entry_value  = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall        = 1'b1;
   logic [fbma_pkg::STATUS_W-1:0]        rsp_status;
   logic signed [fbma_pkg::VALUE_W-1:0]  rsp_read_value;
   logic                                 csr_write        = 1'b0;
   logic [fbma_pkg::CSR_IDX_W-1:0]       csr_index        = '0;
   logic [fbma_pkg::CSR_DATA_W-1:0]      csr_wdata        = '0;

   global_matrix_mirror mirror = new();
   bit                  slot_loaded [ELEM_SLOTS];
   bit                  idle_on      = 1'b0;
   bit                  hold_pending = 1'b0;
   int                  sent         = 0;

   fem_band_matrix_assembler_core #(
      .MAX_DOF      (GRID),
      .MAX_ELEM_DOF (ELEM_SLOTS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_local_row    (req_local_row),
      .req_local_col    (req_local_col),
      .req_global_index (req_global_index),
      .req_store_row    (req_store_row),
      .req_store_col    (req_store_col),
      .req_entry_value  (req_entry_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_read_value   (rsp_read_value),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Entry values: extremes, full range, half range and small Q32.32 numbers
   function automatic logic [fbma_pkg::VALUE_W-1:0] draw_value();
      logic [fbma_pkg::VALUE_W-1:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: v = {1'b0, {(fbma_pkg::VALUE_W-1){1'b1}}};
         1: v = {1'b1, {(fbma_pkg::VALUE_W-1){1'b0}}};
         2, 3: ;
         4: v = $signed(v) >>> 1;
         default: v = $signed(v) >>> $urandom_range(8, 40);
      endcase
      return v;
   endfunction

   // Offer one request beat, after a random gap while idle_on is set, and hold it until taken
   task automatic offer_request(input logic [fbma_pkg::KIND_W-1:0] kind,
                                input logic [fbma_pkg::LIDX_W-1:0] row,
                                input logic [fbma_pkg::LIDX_W-1:0] col,
                                input logic [fbma_pkg::GIDX_W-1:0] gidx,
                                input logic [fbma_pkg::GIDX_W-1:0] srow,
                                input logic [fbma_pkg::GIDX_W-1:0] scol,
                                input logic [fbma_pkg::VALUE_W-1:0] value);
      assembly_request_type rq;
      int                   gap;
      rq  = '{kind, row, col, gidx, srow, scol, value};
      gap = idle_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_local_row    <= row;
      req_local_col    <= col;
      req_global_index <= gidx;
      req_store_row    <= srow;
      req_store_col    <= scol;
      req_entry_value  <= value;
      do @(posedge clock); while (req_stall);
      mirror.apply_request(rq);
      if (kind == fbma_pkg::KIND_LOAD) slot_loaded[row] = 1'b1;
      sent++;
   endtask

   task automatic load_slot(input int slot, input int gidx);
      offer_request(fbma_pkg::KIND_LOAD, fbma_pkg::LIDX_W'(slot),
                    fbma_pkg::LIDX_W'($urandom), fbma_pkg::GIDX_W'(gidx),
                    fbma_pkg::GIDX_W'($urandom), fbma_pkg::GIDX_W'($urandom),
                    draw_value());
   endtask

   task automatic add_entry(input int j, input int i,
                            input logic [fbma_pkg::VALUE_W-1:0] value);
      offer_request(fbma_pkg::KIND_ADD, fbma_pkg::LIDX_W'(j), fbma_pkg::LIDX_W'(i),
                    fbma_pkg::GIDX_W'($urandom), fbma_pkg::GIDX_W'($urandom),
                    fbma_pkg::GIDX_W'($urandom), value);
   endtask

   task automatic read_cell(input int srow, input int scol);
      offer_request(fbma_pkg::KIND_READ, fbma_pkg::LIDX_W'($urandom),
                    fbma_pkg::LIDX_W'($urandom), fbma_pkg::GIDX_W'($urandom),
                    fbma_pkg::GIDX_W'(srow), fbma_pkg::GIDX_W'(scol), draw_value());
   endtask

   // Drop valid, wait for every owed reply, then let the pipeline drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (mirror.pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all four layout registers; the 1-bit ones get junk in the upper bits
   task automatic write_layout(input bit sym, input bit band, input int lbw, input int ubw);
      logic [fbma_pkg::CSR_DATA_W-1:0] data [4];
      logic [fbma_pkg::CSR_IDX_W-1:0]  idx [4];
      data[0] = {5'($urandom), sym};
      data[1] = {5'($urandom), band};
      data[2] = fbma_pkg::CSR_DATA_W'(lbw);
      data[3] = fbma_pkg::CSR_DATA_W'(ubw);
      idx[0]  = fbma_pkg::CSR_SYMMETRIC;
      idx[1]  = fbma_pkg::CSR_BANDED;
      idx[2]  = fbma_pkg::CSR_LOWER_BW;
      idx[3]  = fbma_pkg::CSR_UPPER_BW;
      for (int k = 0; k < 4; k++) begin
         csr_write <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= data[k];
         @(posedge clock);
         mirror.note_register(idx[k], data[k]);
      end
      csr_write <= 1'b0;
   endtask

   // One element: load its DOF map, scatter its entries, read back the last cell hit
   task automatic assemble_element();
      int n, base, spread, adds, j, i;
      idle_on = ($urandom_range(0, 9) < 7);
      n       = ($urandom_range(0, 15) == 0) ? ELEM_SLOTS : $urandom_range(2, 6);
      base    = $urandom_range(0, GRID - 1);
      spread  = ($urandom_range(0, 3) == 0) ? GRID - 1 : $urandom_range(1, 6);
      for (int k = 0; k < n; k++) begin
         load_slot(k, (base + $urandom_range(0, spread)) % GRID);
      end
      adds = (n <= 6) ? n * n : 40;
      for (int k = 0; k < adds; k++) begin
         if (n <= 6) begin
            j = k / n;
            i = k % n;
         end else begin
            j = $urandom_range(0, n - 1);
            i = $urandom_range(0, n - 1);
         end
         add_entry(j, i, draw_value());
      end
      read_cell(mirror.hit_row, mirror.hit_col);
   endtask

   // Noise between elements: stray loads, adds on loaded slots, reads, unknown kinds
   task automatic stray_item();
      int j, i;
      j = $urandom_range(0, ELEM_SLOTS - 1);
      i = $urandom_range(0, ELEM_SLOTS - 1);
      if (!slot_loaded[j]) j = 0;
      if (!slot_loaded[i]) i = 0;
      case ($urandom_range(0, 3))
         0: load_slot(j, $urandom_range(0, GRID - 1));
         1: add_entry(j, i, draw_value());
         2: read_cell($urandom_range(0, GRID - 1), $urandom_range(0, GRID - 1));
         default: offer_request(KIND_NONE, fbma_pkg::LIDX_W'($urandom),
                                fbma_pkg::LIDX_W'($urandom), fbma_pkg::GIDX_W'($urandom),
                                fbma_pkg::GIDX_W'($urandom), fbma_pkg::GIDX_W'($urandom),
                                draw_value());
      endcase
   endtask

   // Reply side: random stall per beat, one long hold-off when asked
   initial begin : reply_sink
      int pause;
      @(negedge reset);
      forever begin
         pause = idle_on ? $urandom_range(0, 11) : 0;
         if (hold_pending) begin
            pause        = LONG_HOLD;
            hold_pending = 1'b0;
         end
         if (pause > 0) begin
            rsp_stall <= 1'b1;
            repeat (pause) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         mirror.compare_reply(rsp_status, rsp_read_value);
      end
   end

   initial begin : watchdog
      #(RUN_LIMIT);
      $display("fem_band_matrix_assembler_core regression: fail");
      $finish;
   end

   initial begin : stimulus
      int start;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Full square storage: saturation both ways, corner cells, unknown kind
      write_layout(0, 0, 0, 0);
      load_slot(0, 0);
      load_slot(31, 63);
      load_slot(1, 5);
      load_slot(2, 6);
      add_entry(0, 0, {1'b0, {(fbma_pkg::VALUE_W-1){1'b1}}});
      add_entry(0, 0, 64'sd1);
      add_entry(31, 31, {1'b1, {(fbma_pkg::VALUE_W-1){1'b0}}});
      add_entry(31, 31, -64'sd1);
      add_entry(31, 0, 64'h0000_0001_8000_0000);
      add_entry(1, 31, -64'sd5);
      read_cell(0, 0);
      read_cell(63, 63);
      read_cell(63, 0);
      offer_request(KIND_NONE, '1, '1, '1, '1, '1, '1);

      // Symmetric band: upper entry skipped, outside band dropped, one kept
      wait_idle();
      write_layout(1, 1, 2, 0);
      add_entry(0, 1, 64'sd9);
      add_entry(1, 0, 64'sd9);
      add_entry(2, 1, 64'sd7);
      read_cell(1, 5);

      // Unsymmetric band at the widest setting: row falls outside the store
      wait_idle();
      write_layout(0, 1, 63, 63);
      add_entry(31, 0, 64'sd11);

      // Unsymmetric band, diagonal only
      wait_idle();
      write_layout(0, 1, 0, 0);
      add_entry(0, 0, 64'sd3);
      add_entry(2, 1, 64'sd4);
      read_cell(0, 0);

      // Random phases, one layout each
      for (int p = 0; p < 9; p++) begin
         wait_idle();
         case (p)
            0: write_layout(0, 0, $urandom_range(0, 20), $urandom_range(0, 20));
            1: write_layout(1, 0, $urandom_range(0, 63), $urandom_range(0, 63));
            2: write_layout(0, 1, 2, 1);
            3: write_layout(1, 1, 3, $urandom_range(0, 63));
            4: write_layout(0, 1, 63, 63);
            5: write_layout(1, 1, 63, 0);
            6: write_layout(0, 1, 0, 0);
            7: write_layout(1, 1, 0, 63);
            default: write_layout($urandom_range(0, 1), $urandom_range(0, 1),
                                  $urandom_range(0, 63), $urandom_range(0, 63));
         endcase
         if (p == 3) hold_pending = 1'b1;
         start = sent;
         while (sent - start < PHASE_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
               repeat ($urandom_range(1, 4)) stray_item();
            end else begin
               assemble_element();
            end
         end
      end

      wait_idle();
      if (mirror.mismatches == 0) begin
         $display("fem_band_matrix_assembler_core regression: pass");
      end else begin
         $display("fem_band_matrix_assembler_core regression: fail");
      end
      $finish;
   end

endmodule
